// ----- src/ppbfm_pkg.sv -----
// shared types and constants for the pipe pool byte fifo manager
package ppbfm_pkg;

  localparam int NUM_PIPES_DEF = 64;
  localparam int BUF_DEPTH_DEF = 4096;
  localparam int ID_W = 32;
  localparam int REF_W = 16;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_OPEN    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_CLOSE   = 3'd3,
    OP_READ    = 3'd4,
    OP_WRITE   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_BLOCK     = 3'd3,
    ST_EOS       = 3'd4,
    ST_REF_LIMIT = 3'd5
  } status_t;

  // update of the slot table from the execute step
  typedef struct packed {
    logic set;
    logic clr;
  } tbl_cmd_t;

  // registered lookup result
  typedef struct packed {
    logic hit;
    logic free_ok;
  } tbl_stat_t;

endpackage

// ----- src/ppbfm_slot_table.sv -----
// slot table: used flags and ids, id lookup and first free slot search
module ppbfm_slot_table #(
  parameter int NUM_PIPES = ppbfm_pkg::NUM_PIPES_DEF,
  parameter int SLOT_W = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      lookup_en,
  input  logic [ppbfm_pkg::ID_W-1:0] lookup_id,
  input  ppbfm_pkg::tbl_cmd_t       cmd,
  input  logic [SLOT_W-1:0]         cmd_slot,
  input  logic [ppbfm_pkg::ID_W-1:0] cmd_id,
  output ppbfm_pkg::tbl_stat_t      stat,
  output logic [SLOT_W-1:0]         hit_slot,
  output logic [SLOT_W-1:0]         free_slot
);
  import ppbfm_pkg::*;

  logic [NUM_PIPES-1:0] used;
  logic [ID_W-1:0]      slot_id [NUM_PIPES];
  logic [NUM_PIPES-1:0] match;
  logic [SLOT_W-1:0]    hit_idx;
  logic [SLOT_W-1:0]    free_idx;
  logic                 free_any;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = 0; i < NUM_PIPES; i++) begin
      match[i] = used[i] && (slot_id[i] == lookup_id) && (lookup_id != '0);
      // ids are unique, so or-ing the matching indices encodes the hit
      if (match[i]) hit_idx = hit_idx | SLOT_W'(i);
    end
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      stat <= '0;
      for (int i = 0; i < NUM_PIPES; i++) slot_id[i] <= '0;
    end else begin
      if (lookup_en) begin
        stat.hit     <= |match;
        stat.free_ok <= free_any;
      end
      if (cmd.set) begin
        used[cmd_slot]    <= 1'b1;
        slot_id[cmd_slot] <= cmd_id;
      end else if (cmd.clr) begin
        used[cmd_slot]    <= 1'b0;
        slot_id[cmd_slot] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      hit_slot  <= hit_idx;
      free_slot <= free_idx;
    end
  end

  a_unique_id: assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("id matches more than one slot");
  a_set_free: assert property (@(posedge clk) disable iff (rst)
    cmd.set |-> !used[cmd_slot])
    else $error("create on a used slot");
  a_clr_used: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> used[cmd_slot])
    else $error("free of an unused slot");

endmodule

// ----- src/pipe_pool_byte_fifo_manager_core.sv -----
// top level: pool of byte fifos with create, open, release, close, read and write
// Each accepted beat passes these steps before its result enters the output register:
// the id compare against all slots (S_MATCH), the read of the slot-state memory (S_META),
// the update of that state and the start of the byte memory access (S_EXEC), and S_DONE,
// in which the byte memory read data is ready and the result is loaded. A beat holds the
// block from its accept until its result is loaded; S_DONE waits while the previous result
// still waits in the output register. The slot-state memory and the byte memory are both
// single-port with a registered read, and one beat is worked on at a time.
// A new beat is taken while the previous result still waits in the output register.
// No clearing pass runs after reset; stored bytes are undefined until written.
module pipe_pool_byte_fifo_manager_core #(
  parameter int NUM_PIPES = ppbfm_pkg::NUM_PIPES_DEF,
  parameter int BUF_DEPTH = ppbfm_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pipe_id[31:0], write_data[39:32]
  input  logic [2:0]  s_axis_tuser,   // opcode
  input  logic        s_axis_tlast,   // last_in_call
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // result_id[31:0], read_data[39:32], slot_freed[40]
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // last_of_call
);
  import ppbfm_pkg::*;

  localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int IDX_W  = $clog2(BUF_DEPTH);
  localparam int FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W = SLOT_W + IDX_W;

  typedef struct packed {
    logic [IDX_W-1:0]  rd;
    logic [IDX_W-1:0]  wr;
    logic [FILL_W-1:0] fill;
    logic [REF_W-1:0]  refc;
    logic              wdone;
  } meta_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_META  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [2:0]      op;
  logic [ID_W-1:0] id;
  logic [7:0]      wdata;
  logic            last;
  logic [ID_W-1:0] next_id;

  tbl_cmd_t          tcmd;
  tbl_stat_t         tstat;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] tslot;

  meta_t meta_mem [NUM_PIPES];
  meta_t meta_q;
  meta_t meta_wdata;
  logic  meta_we;

  logic [7:0]        byte_mem [2**ADDR_W];
  logic [7:0]        byte_q;
  logic [ADDR_W-1:0] byte_addr;
  logic              byte_we;
  logic              byte_re;

  logic [2:0]      res_status;
  logic [ID_W-1:0] res_rid;
  logic            res_rdok;
  logic            res_freed;
  status_t         ex_status;
  logic [ID_W-1:0] ex_rid;
  logic            ex_rdok;
  logic            ex_freed;
  logic            out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  ppbfm_slot_table #(
    .NUM_PIPES(NUM_PIPES),
    .SLOT_W   (SLOT_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .lookup_en(state == S_MATCH),
    .lookup_id(id),
    .cmd      (tcmd),
    .cmd_slot (tslot),
    .cmd_id   (next_id),
    .stat     (tstat),
    .hit_slot (hit_slot),
    .free_slot(free_slot)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_MATCH;
      S_MATCH: state_next = S_META;
      S_META:  state_next = S_EXEC;
      S_EXEC:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // execute step: decide the result and the state updates
  always_comb begin
    ex_status  = ST_OK;
    ex_rid     = id;
    ex_rdok    = 1'b0;
    ex_freed   = 1'b0;
    tcmd       = '0;
    tslot      = hit_slot;
    meta_we    = 1'b0;
    meta_wdata = meta_q;
    byte_we    = 1'b0;
    byte_re    = 1'b0;
    byte_addr  = {hit_slot, meta_q.rd};
    if (state == S_EXEC) begin
      if (op == OP_CREATE) begin
        tslot = free_slot;
        if (!tstat.free_ok || next_id == '0) begin
          ex_status = ST_NO_SLOT;
          ex_rid    = '0;
        end else begin
          ex_rid     = next_id;
          tcmd.set   = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = '0;
          meta_wdata.refc = REF_W'(1);
        end
      end else if (op > OP_WRITE || !tstat.hit) begin
        ex_status = ST_NOT_FOUND;
      end else begin
        case (op)
          OP_OPEN: begin
            if (meta_q.refc == REF_MAX) begin
              ex_status = ST_REF_LIMIT;
            end else begin
              meta_we         = 1'b1;
              meta_wdata.refc = meta_q.refc + 1'b1;
            end
          end
          OP_RELEASE, OP_CLOSE: begin
            if (meta_q.refc <= REF_W'(1)) begin
              tcmd.clr = 1'b1;
              ex_freed = 1'b1;
            end else begin
              meta_we         = 1'b1;
              meta_wdata.refc = meta_q.refc - 1'b1;
              if (op == OP_CLOSE) meta_wdata.wdone = 1'b1;
            end
          end
          OP_READ: begin
            if (meta_q.fill == '0) begin
              ex_status = meta_q.wdone ? ST_EOS : ST_BLOCK;
            end else begin
              ex_rdok         = 1'b1;
              byte_re         = 1'b1;
              meta_we         = 1'b1;
              meta_wdata.rd   = (meta_q.rd == IDX_W'(BUF_DEPTH - 1)) ? '0 : meta_q.rd + 1'b1;
              meta_wdata.fill = meta_q.fill - 1'b1;
            end
          end
          OP_WRITE: begin
            byte_addr = {hit_slot, meta_q.wr};
            if (meta_q.fill >= FILL_W'(BUF_DEPTH)) begin
              ex_status = ST_BLOCK;
            end else begin
              byte_we         = 1'b1;
              meta_we         = 1'b1;
              meta_wdata.wr   = (meta_q.wr == IDX_W'(BUF_DEPTH - 1)) ? '0 : meta_q.wr + 1'b1;
              meta_wdata.fill = meta_q.fill + 1'b1;
            end
          end
          default: ex_status = ST_NOT_FOUND;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[tslot] <= meta_wdata;
    if (state == S_META) meta_q <= meta_mem[hit_slot];
  end

  always_ff @(posedge clk) begin
    if (byte_we) byte_mem[byte_addr] <= wdata;
    if (byte_re) byte_q <= byte_mem[byte_addr];
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op    <= s_axis_tuser;
      id    <= s_axis_tdata[31:0];
      wdata <= s_axis_tdata[39:32];
      last  <= s_axis_tlast;
    end
    if (state == S_EXEC) begin
      res_status <= ex_status;
      res_rid    <= ex_rid;
      res_rdok   <= ex_rdok;
      res_freed  <= ex_freed;
    end
    if (state == S_DONE && out_free) begin
      m_axis_tuser        <= res_status;
      m_axis_tdata[31:0]  <= res_rid;
      m_axis_tdata[39:32] <= res_rdok ? byte_q : 8'd0;
      m_axis_tdata[40]    <= res_freed;
      m_axis_tdata[47:41] <= '0;
      m_axis_tlast        <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_id       <= ID_W'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (tcmd.set) next_id <= next_id + 1'b1;
      if (state == S_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && tstat.hit && op != OP_CREATE) |-> meta_q.fill <= FILL_W'(BUF_DEPTH))
    else $error("fifo fill count beyond depth");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_axis_tvalid)
    else $error("result not presented");
  a_create_id: assert property (@(posedge clk) disable iff (rst)
    tcmd.set |-> next_id != '0)
    else $error("create with exhausted ids");

endmodule
